// ===== rtl/salc_pkg.sv =====
// Package for the set-associative LRU cache simulator.
// Types and constants shared by the front, queue and back modules.
package salc_pkg;

  localparam int unsigned MaxSetsDef  = 64;
  localparam int unsigned MaxWaysDef  = 8;
  localparam int unsigned AgeWidthDef = 8;
  localparam int unsigned AddrWidth   = 64;
  localparam int unsigned CntWidth    = 32;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_STORE  = 2'd1,
    OP_MODIFY = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    OUT_HIT   = 2'd0,
    OUT_MISS  = 2'd1,
    OUT_EVICT = 2'd2,
    OUT_RSVD  = 2'd3
  } outcome_e;

  typedef enum logic [1:0] {
    CFG_SET_BITS   = 2'd0,
    CFG_WAYS       = 2'd1,
    CFG_BLOCK_BITS = 2'd2,
    CFG_RSVD       = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_CLEAR  = 2'd0,
    ST_IDLE   = 2'd1,
    ST_READ   = 2'd2,
    ST_UPDATE = 2'd3
  } back_st_e;

  typedef struct packed {
    logic [1:0]           operation;
    logic [AddrWidth-1:0] address;
  } req_t;

  typedef struct packed {
    logic [1:0]          outcome;
    logic                last_of_access;
    logic [CntWidth-1:0] hit_total;
    logic [CntWidth-1:0] miss_total;
    logic [CntWidth-1:0] evict_total;
  } rsp_t;

  typedef struct packed {
    logic [1:0]           cfg_index;
    logic [CntWidth-1:0]  cfg_data;
  } cfg_t;

  // One pass through the set: block-aligned address already shifted.
  typedef struct packed {
    logic [AddrWidth-1:0] above;
    logic                 last;
  } pass_t;

endpackage

// ===== rtl/salc_ram.sv =====
// Generic simple dual-port RAM (one write port, one read port) with registered read.
// No dependencies.
module salc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// ===== rtl/salc_front.sv =====
// Front end: accepts requests, drops unknown ops, splits modify into two passes.
// Depends on salc_pkg.
module salc_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                req_valid_i,
  output logic                req_ready_o,
  input  salc_pkg::req_t      req_i,
  input  logic [4:0]          block_bits_i,
  output logic                pass_valid_o,
  input  logic                pass_ready_i,
  output salc_pkg::pass_t     pass_o
);
  import salc_pkg::*;

  logic                 second_q, second_d;
  logic [AddrWidth-1:0] above_q, above_d;
  logic                 acc;

  assign req_ready_o = !second_q && pass_ready_i;
  assign acc = req_valid_i && req_ready_o;

  always_comb begin
    second_d     = second_q;
    above_d      = above_q;
    pass_valid_o = 1'b0;
    pass_o.above = req_i.address >> block_bits_i;
    pass_o.last  = 1'b1;
    if (second_q) begin
      pass_valid_o = 1'b1;
      pass_o.above = above_q;
      if (pass_ready_i) second_d = 1'b0;
    end else if (req_valid_i && op_e'(req_i.operation) != OP_NONE) begin
      pass_valid_o = 1'b1;
      if (op_e'(req_i.operation) == OP_MODIFY) begin
        pass_o.last = 1'b0;
        if (acc) begin
          second_d = 1'b1;
          above_d  = pass_o.above;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      second_q <= 1'b0;
    end else begin
      second_q <= second_d;
    end
  end

  always_ff @(posedge clk_i) begin
    above_q <= above_d;
  end
endmodule

// ===== rtl/salc_queue.sv =====
// Two-entry queue between front and back ends.
// Depends on salc_pkg.
module salc_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  salc_pkg::pass_t in_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output salc_pkg::pass_t out_o
);
  import salc_pkg::*;

  pass_t      ent_q [2];
  logic       rd_q, wr_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign in_ready_o  = cnt_q != 2'd2;
  assign out_valid_o = cnt_q != 2'd0;
  assign out_o       = ent_q[rd_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q  <= 1'b0;
      wr_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= !wr_q;
      if (pop) rd_q <= !rd_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) ent_q[wr_q] <= in_i;
  end
endmodule

// ===== rtl/salc_back.sv =====
// Back end: set read, tag compare, LRU update and counters; output register.
// Depends on salc_pkg and salc_ram.
module salc_back #(
  parameter int unsigned MaxSets  = salc_pkg::MaxSetsDef,
  parameter int unsigned MaxWays  = salc_pkg::MaxWaysDef,
  parameter int unsigned AgeWidth = salc_pkg::AgeWidthDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            pass_valid_i,
  output logic            pass_ready_o,
  input  salc_pkg::pass_t pass_i,
  input  logic [2:0]      set_bits_i,
  input  logic [3:0]      ways_in_use_i,
  output logic            rsp_valid_o,
  input  logic            rsp_ready_i,
  output salc_pkg::rsp_t  rsp_o
);
  import salc_pkg::*;

  localparam int unsigned SetW = (MaxSets > 1) ? $clog2(MaxSets) : 1;
  localparam int unsigned MaxSb = $clog2(MaxSets + 1) - 1;
  localparam int unsigned WayW = $clog2(MaxWays + 1);
  localparam int unsigned LineW = AddrWidth + AgeWidth + 1;
  localparam logic [AgeWidth-1:0] AgeMax = {AgeWidth{1'b1}};

  back_st_e st_q, st_d;
  logic [SetW-1:0]      clr_q;
  logic [AddrWidth-1:0] tag_q;
  logic [SetW-1:0]      set_q;
  logic                 last_q;
  logic [CntWidth-1:0] hits_q, miss_q, evict_q;
  rsp_t rsp_q;
  logic rsp_valid_q;

  logic [3:0] sb_eff;
  logic [WayW-1:0] ways_eff;
  logic [AddrWidth-1:0] set_mask;
  logic            line_we;
  logic [SetW-1:0] line_waddr;
  logic [MaxWays-1:0][LineW-1:0] line_rd, line_wr;

  always_comb begin
    sb_eff = ({1'b0, set_bits_i} > 4'(MaxSb)) ? 4'(MaxSb) : {1'b0, set_bits_i};
    if (ways_in_use_i == 4'd0) ways_eff = WayW'(1);
    else if (32'(ways_in_use_i) > MaxWays) ways_eff = WayW'(MaxWays);
    else ways_eff = WayW'(ways_in_use_i);
    set_mask = ~({AddrWidth{1'b1}} << sb_eff);
  end

  // line layout: {valid, age, tag}
  assign line_we    = st_q == ST_CLEAR || st_q == ST_UPDATE;
  assign line_waddr = (st_q == ST_CLEAR) ? clr_q : set_q;

  for (genvar g = 0; g < MaxWays; g++) begin : g_way
    salc_ram #(.Width(LineW), .Depth(MaxSets)) u_lines (
      .clk_i,
      .we_i   (line_we),
      .waddr_i(line_waddr),
      .wdata_i((st_q == ST_CLEAR) ? {LineW{1'b0}} : line_wr[g]),
      .raddr_i(set_q),
      .rdata_o(line_rd[g])
    );
  end

  assign pass_ready_o = st_q == ST_IDLE && (!rsp_valid_q || rsp_ready_i);
  assign rsp_valid_o  = rsp_valid_q;
  assign rsp_o        = rsp_q;

  logic [MaxWays-1:0] hit_vec, free_vec, in_use, way_valid;
  logic [MaxWays-1:0][AgeWidth-1:0]  way_age;
  logic [MaxWays-1:0][AddrWidth-1:0] way_tag;
  logic               found, have_free;
  logic [WayW-1:0]    used;
  logic [AgeWidth-1:0] best_age;
  outcome_e           oc;

  always_comb begin
    found = 1'b0;
    have_free = 1'b0;
    used = '0;
    best_age = '0;
    for (int w = 0; w < MaxWays; w++) begin
      way_valid[w] = line_rd[w][LineW-1];
      way_age[w]   = line_rd[w][AddrWidth +: AgeWidth];
      way_tag[w]   = line_rd[w][AddrWidth-1:0];
      in_use[w]    = WayW'(w) < ways_eff;
      hit_vec[w]   = in_use[w] && way_valid[w] && way_tag[w] == tag_q;
      free_vec[w]  = in_use[w] && !way_valid[w];
    end
    for (int w = MaxWays - 1; w >= 0; w--) begin
      if (hit_vec[w]) begin
        found = 1'b1;
        used = WayW'(w);
      end
    end
    if (!found) begin
      for (int w = MaxWays - 1; w >= 0; w--) begin
        if (free_vec[w]) begin
          have_free = 1'b1;
          used = WayW'(w);
        end
      end
    end
    if (!found && !have_free) begin
      used = '0;
      best_age = way_age[0];
      for (int w = 1; w < MaxWays; w++) begin
        if (in_use[w] && way_age[w] > best_age) begin
          best_age = way_age[w];
          used = WayW'(w);
        end
      end
    end
    oc = found ? OUT_HIT : (have_free ? OUT_MISS : OUT_EVICT);
  end

  always_comb begin
    for (int w = 0; w < MaxWays; w++) begin
      line_wr[w] = {way_valid[w], way_age[w], way_tag[w]};
      if (in_use[w]) begin
        if (!found && used == WayW'(w)) begin
          line_wr[w][LineW-1]       = 1'b1;
          line_wr[w][AddrWidth-1:0] = tag_q;
        end
        if (used == WayW'(w) || !way_valid[w]) line_wr[w][AddrWidth +: AgeWidth] = '0;
        else if (way_age[w] != AgeMax)
          line_wr[w][AddrWidth +: AgeWidth] = way_age[w] + 1'b1;
      end
    end
  end

  always_comb begin
    st_d = st_q;
    case (st_q)
      ST_CLEAR:  if (clr_q == SetW'(MaxSets - 1)) st_d = ST_IDLE;
      ST_IDLE:   if (pass_valid_i && pass_ready_o) st_d = ST_READ;
      ST_READ:   st_d = ST_UPDATE;
      ST_UPDATE: st_d = ST_IDLE;
      default:   st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_CLEAR;
      clr_q       <= '0;
      hits_q      <= '0;
      miss_q      <= '0;
      evict_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (st_q == ST_CLEAR) clr_q <= clr_q + 1'b1;
      if (rsp_valid_q && rsp_ready_i) rsp_valid_q <= 1'b0;
      if (st_q == ST_UPDATE) begin
        rsp_valid_q <= 1'b1;
        if (oc == OUT_HIT) hits_q <= hits_q + 1'b1;
        else miss_q <= miss_q + 1'b1;
        if (oc == OUT_EVICT) evict_q <= evict_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pass_valid_i && pass_ready_o) begin
      tag_q  <= pass_i.above >> sb_eff;
      set_q  <= SetW'(pass_i.above & set_mask);
      last_q <= pass_i.last;
    end
    if (st_q == ST_UPDATE) begin
      rsp_q.outcome        <= oc;
      rsp_q.last_of_access <= last_q;
      rsp_q.hit_total      <= (oc == OUT_HIT) ? hits_q + 1'b1 : hits_q;
      rsp_q.miss_total     <= (oc != OUT_HIT) ? miss_q + 1'b1 : miss_q;
      rsp_q.evict_total    <= (oc == OUT_EVICT) ? evict_q + 1'b1 : evict_q;
    end
  end
endmodule

// ===== rtl/set_assoc_lru_cache_sim.sv =====
// Set-associative LRU cache hit/miss simulator, top level.
// Each access pass goes through accept, set read and set update; the back end takes
// a new pass only when idle with its result register free or draining. A modify
// takes 2 passes. Reset: counters cleared, config set to defaults at once; a clearing
// pass zeroes the line RAMs before the first pass. Depends on salc_pkg and submodules.
module set_assoc_lru_cache_sim #(
  parameter int unsigned MaxSets  = salc_pkg::MaxSetsDef,
  parameter int unsigned MaxWays  = salc_pkg::MaxWaysDef,
  parameter int unsigned AgeWidth = salc_pkg::AgeWidthDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           req_valid_i,
  output logic           req_ready_o,
  input  salc_pkg::req_t req_i,
  output logic           rsp_valid_o,
  input  logic           rsp_ready_i,
  output salc_pkg::rsp_t rsp_o,
  input  logic           cfg_valid_i,
  output logic           cfg_ready_o,
  input  salc_pkg::cfg_t cfg_i
);
  import salc_pkg::*;

  logic [2:0] set_bits_q;
  logic [3:0] ways_q;
  logic [4:0] block_bits_q;
  logic       fp_valid, fp_ready, qb_valid, qb_ready;
  pass_t      fp, qb;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      set_bits_q   <= 3'd4;
      ways_q       <= 4'd1;
      block_bits_q <= 5'd4;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_i.cfg_index))
        CFG_SET_BITS:   set_bits_q   <= cfg_i.cfg_data[2:0];
        CFG_WAYS:       ways_q       <= cfg_i.cfg_data[3:0];
        CFG_BLOCK_BITS: block_bits_q <= cfg_i.cfg_data[4:0];
        default: ;
      endcase
    end
  end

  salc_front u_front (
    .clk_i, .rst_ni,
    .req_valid_i, .req_ready_o, .req_i,
    .block_bits_i(block_bits_q),
    .pass_valid_o(fp_valid), .pass_ready_i(fp_ready), .pass_o(fp)
  );

  salc_queue u_queue (
    .clk_i, .rst_ni,
    .in_valid_i(fp_valid), .in_ready_o(fp_ready), .in_i(fp),
    .out_valid_o(qb_valid), .out_ready_i(qb_ready), .out_o(qb)
  );

  salc_back #(.MaxSets(MaxSets), .MaxWays(MaxWays), .AgeWidth(AgeWidth)) u_back (
    .clk_i, .rst_ni,
    .pass_valid_i(qb_valid), .pass_ready_o(qb_ready), .pass_i(qb),
    .set_bits_i(set_bits_q), .ways_in_use_i(ways_q),
    .rsp_valid_o, .rsp_ready_i, .rsp_o
  );
endmodule
